@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent checks on the local clk, off while rst is high
`define GPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// implication form: cond at an edge requires expr at that edge
`define GPG_ASSERT_IMPL(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
`endif

@@ rtl/core/gpg_pkg.sv @@
package gpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int PT_W       = 15;
  localparam int DIFF_W     = 16;
  localparam int AX_W       = 17;
  localparam int PROD_W     = DIFF_W + AX_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int LEN_W      = 32;
  localparam int D2_W       = 2 * DIFF_W;
  localparam int SQ_IN_W    = D2_W + 8;
  localparam int ROOT_W     = SQ_IN_W / 2;
  localparam int SQ_RW      = ROOT_W + 2;
  localparam int RAD_W      = 16;
  localparam int DIV_W      = 32;
  localparam int Q_W        = 8;
  localparam int T_W        = Q_W + 1;
  localparam int COLOR_W    = 32;
  localparam int CH_W       = 8;
  localparam int N_CH       = COLOR_W / CH_W;
  localparam int BL_W       = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [T_W-1:0] T_ONE = T_W'(256);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_X0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_Y0    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_X1    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_Y1    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 3'd7;

  typedef struct packed {
    logic                    mode;
    logic [COLOR_W-1:0]      color_start;
    logic [COLOR_W-1:0]      color_end;
    logic signed [PT_W-1:0]  x0;
    logic signed [PT_W-1:0]  y0;
    logic signed [PT_W-1:0]  x1;
    logic signed [PT_W-1:0]  y1;
    logic [RAD_W-1:0]        radius;
  } cfg_t;

  // per-pixel values after the product stages
  typedef struct packed {
    logic                    radial;
    logic signed [NUM_W-1:0] num;
    logic [LEN_W-1:0]        len2;
    logic [D2_W-1:0]         d2;
  } pre_t;

  // fraction source carried alongside the divider
  typedef struct packed {
    logic           use_div;
    logic [T_W-1:0] fixed_t;
  } div_side_t;

endpackage

@@ rtl/core/gpg_if.sv @@
interface gpg_pix_in_if import gpg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface gpg_pix_out_if import gpg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_argb;
  modport source (output valid, pixel_argb, input ready);
  modport sink (input valid, pixel_argb, output ready);
endinterface

interface gpg_cfg_if import gpg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/gradient_pixel_generator_unit.sv @@
// gradient fill pixel generator
// pix_in carries one pixel coordinate (pixel_x, pixel_y) per transfer and
// pix_out returns its ARGB colour, alpha in the top byte. cfg writes one of
// the eight registers by index (mode, colours, points, radius) and is always
// ready; write it only while no pixel is in flight.
// throughput: one pixel per clock in both modes while the receiver is ready.
// stages from the input transfer to the output transfer: three stages of
// offsets and products, 20 square-root stages (one root bit each), a
// selection stage, 8 divider stages (one fraction bit each), the channel
// blend stage and the output register.
// the whole pipeline moves on one enable taken from a registered skid flag,
// so pix_in.ready never depends on pix_out.ready in the same cycle. when the
// receiver stalls, one more result parks in the skid entry and then the
// pipeline freezes with every item in place; nothing is dropped or repeated.
// reset (rst, synchronous) zeroes the config registers and empties all valid
// bits; pix_in.ready is high in the first cycle after reset.
module gradient_pixel_generator_unit import gpg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  gpg_pix_in_if.sink    pix_in,
  gpg_pix_out_if.source pix_out,
  gpg_cfg_if.sink       cfg
);

  cfg_t              regs;
  logic              en;

  // offsets, products and sums
  logic              pre_v;
  pre_t              pre;

  // distance root, linear values ride along
  logic              sq_v;
  pre_t              sq_pre;
  logic [ROOT_W-1:0] sq_root;

  // selection stage: end cases resolved, divider operands picked
  logic              sel_v;
  div_side_t         sel_side, sel_side_c;
  logic [DIV_W-1:0]  sel_n, sel_n_c;
  logic [DIV_W-1:0]  sel_d, sel_d_c;
  logic [ROOT_W-1:0] r16;

  // fraction
  logic              dv_v;
  div_side_t         dv_side;
  logic [Q_W-1:0]    dv_q;

  assign pix_in.ready = en;

  gpg_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  gpg_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (pix_in.valid),
    .px    (pix_in.pixel_x),
    .py    (pix_in.pixel_y),
    .regs  (regs),
    .out_v (pre_v),
    .pre   (pre)
  );

  gpg_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (pre_v),
    .in_pre  (pre),
    .out_v   (sq_v),
    .out_pre (sq_pre),
    .root    (sq_root)
  );

  // radius in the same 1/16 pixel scale as the root
  assign r16 = ROOT_W'({regs.radius, 4'b0000});

  always_comb begin
    sel_side_c = '0;
    sel_n_c    = '0;
    sel_d_c    = '0;
    if (sq_pre.radial) begin
      if (regs.radius == '0) begin
        // zero radius paints the outer colour
        sel_side_c.fixed_t = T_ONE;
      end else if (sq_root == '0) begin
        sel_side_c.fixed_t = '0;
      end else if (sq_root >= r16) begin
        sel_side_c.fixed_t = T_ONE;
      end else begin
        sel_side_c.use_div = 1'b1;
        sel_n_c = DIV_W'(sq_root);
        sel_d_c = DIV_W'(r16);
      end
    end else begin
      if (sq_pre.len2 == '0) begin
        // zero-length axis paints the start colour
        sel_side_c.fixed_t = '0;
      end else if (sq_pre.num[NUM_W-1] || sq_pre.num == '0) begin
        sel_side_c.fixed_t = '0;
      end else if ($signed(sq_pre.num) >=
                   $signed({{(NUM_W-LEN_W){1'b0}}, sq_pre.len2})) begin
        sel_side_c.fixed_t = T_ONE;
      end else begin
        sel_side_c.use_div = 1'b1;
        sel_n_c = sq_pre.num[DIV_W-1:0];
        sel_d_c = sq_pre.len2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_v <= 1'b0;
    end else if (en) begin
      sel_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_side <= sel_side_c;
      sel_n    <= sel_n_c;
      sel_d    <= sel_d_c;
    end
  end

  gpg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (sel_v),
    .in_side  (sel_side),
    .num      (sel_n),
    .den      (sel_d),
    .out_v    (dv_v),
    .out_side (dv_side),
    .q        (dv_q)
  );

  gpg_blend u_blend (
    .clk     (clk),
    .rst     (rst),
    .in_v    (dv_v),
    .side    (dv_side),
    .q       (dv_q),
    .regs    (regs),
    .en      (en),
    .pix_out (pix_out)
  );

endmodule

@@ rtl/core/gpg_cfg.sv @@
module gpg_cfg import gpg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  gpg_cfg_if.sink   cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MODE:        regs.mode        <= cfg.data[0];
        REG_COLOR_START: regs.color_start <= cfg.data[COLOR_W-1:0];
        REG_COLOR_END:   regs.color_end   <= cfg.data[COLOR_W-1:0];
        REG_POINT_X0:    regs.x0          <= cfg.data[PT_W-1:0];
        REG_POINT_Y0:    regs.y0          <= cfg.data[PT_W-1:0];
        REG_POINT_X1:    regs.x1          <= cfg.data[PT_W-1:0];
        REG_POINT_Y1:    regs.y1          <= cfg.data[PT_W-1:0];
        REG_RADIUS:      regs.radius      <= cfg.data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/gpg_front.sv @@
module gpg_front import gpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_v,
  input  logic [COORD_BITS-1:0] px,
  input  logic [COORD_BITS-1:0] py,
  input  cfg_t                  regs,
  output logic                  out_v,
  output pre_t                  pre
);

  // stage 1: offsets and axis
  logic                     v1, rad1;
  logic signed [DIFF_W-1:0] dpx, dpy;
  logic signed [AX_W-1:0]   ax, ay;
  // stage 2: products
  logic                     v2, rad2;
  logic signed [PROD_W-1:0] plx, ply;
  logic [D2_W-1:0]          sqx, sqy;
  logic [LEN_W-1:0]         llx, lly;

  logic signed [PROD_W-1:0]   plx_c, ply_c;
  logic signed [D2_W-1:0]     sqx_c, sqy_c;
  logic signed [2*AX_W-1:0]   llx_c, lly_c;

  assign plx_c = dpx * ax;
  assign ply_c = dpy * ay;
  assign sqx_c = dpx * dpx;
  assign sqy_c = dpy * dpy;
  assign llx_c = ax * ax;
  assign lly_c = ay * ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
      v2 <= v1;
      out_v <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad1 <= regs.mode;
      dpx  <= $signed({{(DIFF_W-COORD_BITS){1'b0}}, px}) - DIFF_W'(regs.x0);
      dpy  <= $signed({{(DIFF_W-COORD_BITS){1'b0}}, py}) - DIFF_W'(regs.y0);
      ax   <= AX_W'(regs.x1) - AX_W'(regs.x0);
      ay   <= AX_W'(regs.y1) - AX_W'(regs.y0);

      rad2 <= rad1;
      plx  <= plx_c;
      ply  <= ply_c;
      sqx  <= $unsigned(sqx_c);
      sqy  <= $unsigned(sqy_c);
      llx  <= LEN_W'($unsigned(llx_c));
      lly  <= LEN_W'($unsigned(lly_c));

      pre.radial <= rad2;
      pre.num    <= NUM_W'(plx) + NUM_W'(ply);
      pre.len2   <= llx + lly;
      pre.d2     <= sqx + sqy;
    end
  end

endmodule

@@ rtl/core/gpg_sqrt.sv @@
module gpg_sqrt import gpg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_v,
  input  pre_t              in_pre,
  output logic              out_v,
  output pre_t              out_pre,
  output logic [ROOT_W-1:0] root
);

  typedef struct packed {
    logic [SQ_IN_W-1:0] val;
    logic [SQ_RW-1:0]   rem;
    logic [ROOT_W-1:0]  root;
  } sq_t;

  // one result bit per stage, two radicand bits consumed
  function automatic sq_t sq_step(sq_t p);
    logic [SQ_RW-1:0] cur;
    logic [SQ_RW-1:0] trial;
    sq_t r;
    cur   = {p.rem[SQ_RW-3:0], p.val[SQ_IN_W-1 -: 2]};
    trial = {p.root, 2'b01};
    r.val = p.val << 2;
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {p.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {p.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [ROOT_W-1:0] vld;
  sq_t               st   [ROOT_W];
  sq_t               nxt  [ROOT_W];
  pre_t              side [ROOT_W];
  sq_t               start;

  assign start = '{val: {in_pre.d2, 8'h00}, rem: '0, root: '0};

  always_comb begin
    nxt[0] = sq_step(start);
    for (int k = 1; k < ROOT_W; k++) begin
      nxt[k] = sq_step(st[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROOT_W-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_pre;
      for (int k = 0; k < ROOT_W; k++) begin
        st[k] <= nxt[k];
      end
      for (int k = 1; k < ROOT_W; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  assign out_v   = vld[ROOT_W-1];
  assign out_pre = side[ROOT_W-1];
  assign root    = st[ROOT_W-1].root;

endmodule

@@ rtl/core/gpg_div.sv @@
module gpg_div import gpg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  div_side_t        in_side,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             out_v,
  output div_side_t        out_side,
  output logic [Q_W-1:0]   q
);

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] den;
    logic [Q_W-1:0]   q;
  } dv_t;

  // restoring step, numerator below the divisor on entry
  function automatic dv_t dv_step(dv_t p);
    logic [DIV_W:0] r2;
    dv_t r;
    r2    = {p.rem, 1'b0};
    r.den = p.den;
    if (r2 >= {1'b0, p.den}) begin
      r.rem = DIV_W'(r2 - {1'b0, p.den});
      r.q   = {p.q[Q_W-2:0], 1'b1};
    end else begin
      r.rem = DIV_W'(r2);
      r.q   = {p.q[Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [Q_W-1:0] vld;
  dv_t            st   [Q_W];
  dv_t            nxt  [Q_W];
  div_side_t      side [Q_W];
  dv_t            start;

  assign start = '{rem: num, den: den, q: '0};

  always_comb begin
    nxt[0] = dv_step(start);
    for (int k = 1; k < Q_W; k++) begin
      nxt[k] = dv_step(st[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Q_W-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int k = 0; k < Q_W; k++) begin
        st[k] <= nxt[k];
      end
      for (int k = 1; k < Q_W; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  assign out_v    = vld[Q_W-1];
  assign out_side = side[Q_W-1];
  assign q        = st[Q_W-1].q;

endmodule

@@ rtl/core/gpg_blend.sv @@
`include "assert_macros.svh"

module gpg_blend import gpg_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_v,
  input  div_side_t      side,
  input  logic [Q_W-1:0] q,
  input  cfg_t           regs,
  output logic           en,
  gpg_pix_out_if.source  pix_out
);

  logic [T_W-1:0]          t_c;
  logic signed [CH_W+1:0]  delta [N_CH];
  logic signed [BL_W-1:0]  prod  [N_CH];
  logic [COLOR_W-1:0]      argb_c;

  logic                    bl_v;
  logic [COLOR_W-1:0]      bl_argb;
  logic                    out_v;
  logic [COLOR_W-1:0]      out_argb;
  logic                    skid_v;
  logic [COLOR_W-1:0]      skid_argb;
  logic                    pop;

  always_comb begin
    t_c    = side.use_div ? {1'b0, q} : side.fixed_t;
    argb_c = '0;
    for (int c = 0; c < N_CH; c++) begin
      delta[c] = $signed({2'b00, regs.color_end[CH_W*c +: CH_W]})
               - $signed({2'b00, regs.color_start[CH_W*c +: CH_W]});
      prod[c]  = delta[c] * $signed({1'b0, t_c}) + BL_W'(128);
      // floor of the rounded product over 256, taken mod 256
      argb_c[CH_W*c +: CH_W] = regs.color_start[CH_W*c +: CH_W] + prod[c][2*CH_W-1:CH_W];
    end
  end

  assign en  = !skid_v;
  assign pop = out_v && pix_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bl_v   <= 1'b0;
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (en) begin
        bl_v <= in_v;
      end
      if (skid_v) begin
        if (pop) begin
          skid_v <= 1'b0;
        end
      end else if (bl_v) begin
        if (out_v && !pop) begin
          skid_v <= 1'b1;
        end else begin
          out_v <= 1'b1;
        end
      end else if (pop) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bl_argb <= argb_c;
    end
    if (skid_v) begin
      if (pop) begin
        out_argb <= skid_argb;
      end
    end else if (bl_v) begin
      if (out_v && !pop) begin
        skid_argb <= bl_argb;
      end else begin
        out_argb <= bl_argb;
      end
    end
  end

  assign pix_out.valid      = out_v;
  assign pix_out.pixel_argb = out_argb;

  `GPG_ASSERT(a_skid_behind_out, (skid_v |-> out_v), "skid entry held without output entry")
  `GPG_ASSERT_IMPL(a_skid_fill, $rose(skid_v), $past(out_v && !pix_out.ready),
    "skid filled while output was free")
  `GPG_ASSERT_IMPL(a_fixed_t, in_v && !side.use_div,
    side.fixed_t == '0 || side.fixed_t == T_ONE, "fixed fraction not at an end")

endmodule

@@ verif/gpg_checker.sv @@
`timescale 1ns / 1ps
module gpg_checker import gpg_pkg::*; (
  input  logic clk,
  input  logic rst,
  gpg_pix_in_if.sink  pix_in_mon,
  gpg_pix_out_if.sink pix_out_mon,
  gpg_cfg_if.sink     cfg_mon,
  output int          fail_count,
  output int          pending_count,
  output int          argb_seen
);
  logic                  mode_q;
  logic [31:0]           start_q, end_q;
  longint                x0_q, y0_q, x1_q, y1_q;
  logic [15:0]           radius_q;
  logic [COLOR_W-1:0]    argb_queue[$];

  function automatic longint sx15(logic [31:0] v);
    logic signed [14:0] s;
    s = v[14:0];
    return longint'(s);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [31:0] mix_argb(logic [31:0] a, logic [31:0] b, int t);
    logic [31:0] o;
    int ca, cb, v;
    o = 0;
    for (int k = 0; k < 4; k++) begin
      ca = int'(a[k*8 +: 8]);
      cb = int'(b[k*8 +: 8]);
      v = (cb - ca) * t + 128 + 65536;
      o[k*8 +: 8] = 8'(ca + (v >>> 8) - 256);
    end
    return o;
  endfunction

  function automatic logic [31:0] shade_pixel(longint px, longint py);
    longint dx, dy, len2, num, d16, r16;
    int t;
    if (!mode_q) begin
      dx = x1_q - x0_q;
      dy = y1_q - y0_q;
      len2 = dx * dx + dy * dy;
      if (len2 == 0) return start_q;
      num = (px - x0_q) * dx + (py - y0_q) * dy;
      if (num <= 0) t = 0;
      else if (num >= len2) t = 256;
      else t = int'((num * 256) / len2);
    end else begin
      if (radius_q == 0) return end_q;
      dx = px - x0_q;
      dy = py - y0_q;
      d16 = int_sqrt(longint'((dx * dx + dy * dy) * 256));
      r16 = longint'(radius_q) * 16;
      if (d16 == 0) t = 0;
      else if (d16 >= r16) t = 256;
      else t = int'((d16 * 256) / r16);
    end
    return mix_argb(start_q, end_q, t);
  endfunction

  assign pending_count = argb_queue.size();

  always @(posedge clk) begin
    if (rst) begin
      mode_q <= 0; start_q <= 0; end_q <= 0; radius_q <= 0;
      x0_q <= 0; y0_q <= 0; x1_q <= 0; y1_q <= 0;
      argb_queue.delete();
      fail_count <= 0;
      argb_seen <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_MODE:        mode_q <= cfg_mon.data[0];
          REG_COLOR_START: start_q <= cfg_mon.data;
          REG_COLOR_END:   end_q <= cfg_mon.data;
          REG_POINT_X0:    x0_q <= sx15(cfg_mon.data);
          REG_POINT_Y0:    y0_q <= sx15(cfg_mon.data);
          REG_POINT_X1:    x1_q <= sx15(cfg_mon.data);
          REG_POINT_Y1:    y1_q <= sx15(cfg_mon.data);
          REG_RADIUS:      radius_q <= cfg_mon.data[15:0];
          default: ;
        endcase
      end
      if (pix_in_mon.valid && pix_in_mon.ready)
        argb_queue.push_back(shade_pixel(longint'(pix_in_mon.pixel_x),
                                         longint'(pix_in_mon.pixel_y)));
      if (pix_out_mon.valid && pix_out_mon.ready) begin
        argb_seen <= argb_seen + 1;
        if (argb_queue.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual %08h", $time,
                   pix_out_mon.pixel_argb);
          fail_count <= fail_count + 1;
        end else if (argb_queue[0] !== pix_out_mon.pixel_argb) begin
          $display("%0t: pixel_argb mismatch, expected %08h, actual %08h", $time,
                   argb_queue[0], pix_out_mon.pixel_argb);
          fail_count <= fail_count + 1;
          void'(argb_queue.pop_front());
        end else begin
          void'(argb_queue.pop_front());
        end
      end
    end
  end
endmodule

@@ verif/tb_gradient_pixel_generator_unit.sv @@
`timescale 1ns / 1ps
module tb_gradient_pixel_generator_unit;
  import gpg_pkg::*;

  localparam int PIPE_LAT = 34;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending_count, argb_seen;
  int   idle_cycles;
  int   send_gap, sink_gap;   // idle cycles of the current burst; sink_gap counts down what is left
  bit   calm;                 // no idling in the last part
  int   pix_total;

  gpg_pix_in_if  pix_in();
  gpg_pix_out_if pix_out();
  gpg_cfg_if     cfg();

  gradient_pixel_generator_unit dut (
    .clk(clk), .rst(rst), .pix_in(pix_in.sink), .pix_out(pix_out.source), .cfg(cfg.sink)
  );

  gpg_checker chk (
    .clk(clk), .rst(rst), .pix_in_mon(pix_in.sink), .pix_out_mon(pix_out.sink),
    .cfg_mon(cfg.sink), .fail_count(fail_count), .pending_count(pending_count),
    .argb_seen(argb_seen)
  );

  always #5 clk = ~clk;

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
        || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver stalls in random bursts, none once the run calms down
  initial begin
    pix_out.ready = 0;
    sink_gap = 0;
    forever begin
      @(negedge clk);
      if (calm || rst) begin
        pix_out.ready <= !rst;
      end else if (sink_gap > 0) begin
        sink_gap--;
        pix_out.ready <= 0;
      end else if ($urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(1, 15) - 1;
        pix_out.ready <= 0;
      end else begin
        pix_out.ready <= 1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg.index <= idx;
    cfg.data <= val;
    cfg.valid <= 1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 0;
    @(negedge clk);
  endtask

  // one coordinate transfer, with an optional idle burst in front of it
  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    if (!calm && $urandom_range(0, 11) == 0) begin
      send_gap = $urandom_range(1, 15);
      pix_in.valid <= 0;
      repeat (send_gap) @(negedge clk);
    end
    pix_in.pixel_x <= px;
    pix_in.pixel_y <= py;
    pix_in.valid <= 1;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    @(negedge clk);
    pix_total++;
  endtask

  // let the pipeline drain before touching registers
  task automatic drain;
    pix_in.valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic random_setup;
    write_reg(REG_MODE, 32'($urandom_range(0, 1)));
    write_reg(REG_COLOR_START, $urandom());
    write_reg(REG_COLOR_END, $urandom());
    for (int r = REG_POINT_X0; r <= REG_POINT_Y1; r++) begin
      // mostly points near the coordinate range, sometimes anywhere
      if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_W'(r), $urandom());
      else write_reg(CFG_IDX_W'(r), 32'($urandom_range(0, 4600)) - 32'd300);
    end
    case ($urandom_range(0, 4))
      0: write_reg(REG_RADIUS, 0);
      1: write_reg(REG_RADIUS, 32'hffff);
      2: write_reg(REG_RADIUS, $urandom());
      default: write_reg(REG_RADIUS, 32'($urandom_range(1, 3000)));
    endcase
  endtask

  initial begin
    pix_in.valid = 0;
    pix_in.pixel_x = 0;
    pix_in.pixel_y = 0;
    cfg.valid = 0;
    cfg.index = 0;
    cfg.data = 0;
    calm = 0;
    pix_total = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // reset values: zero-length axis gives the start colour
    send_pixel(12'd5, 12'd9);
    drain();

    // linear, diagonal axis across the whole plane, extremes of the coordinates
    write_reg(REG_COLOR_START, 32'h00ff_80ff);
    write_reg(REG_COLOR_END, 32'hff00_7f00);
    write_reg(REG_POINT_X0, 32'h4000);        // most negative
    write_reg(REG_POINT_Y0, 32'h4000);
    write_reg(REG_POINT_X1, 32'h3fff);        // most positive
    write_reg(REG_POINT_Y1, 32'h3fff);
    send_pixel(12'h000, 12'h000);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'hfff, 12'h000);
    send_pixel(12'h555, 12'haaa);
    drain();
    // short axis so pixels before, inside and past it
    write_reg(REG_POINT_X0, 32'd100);
    write_reg(REG_POINT_Y0, 32'd100);
    write_reg(REG_POINT_X1, 32'd110);
    write_reg(REG_POINT_Y1, 32'd100);
    send_pixel(12'd50, 12'd7);
    send_pixel(12'd105, 12'd100);
    send_pixel(12'd110, 12'd0);
    send_pixel(12'd4000, 12'd100);
    drain();
    // radial: zero radius gives the end colour, then centre, edge and far away
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_RADIUS, 32'd0);
    send_pixel(12'd100, 12'd100);
    drain();
    write_reg(REG_RADIUS, 32'd20);
    send_pixel(12'd100, 12'd100);
    send_pixel(12'd120, 12'd100);
    send_pixel(12'd107, 12'd111);
    send_pixel(12'hfff, 12'hfff);
    drain();
    // far centre with largest radius: full-width distance
    write_reg(REG_POINT_X0, 32'h4000);
    write_reg(REG_POINT_Y0, 32'h4000);
    write_reg(REG_RADIUS, 32'hffff);
    write_reg(REG_COLOR_START, 32'hffff_ffff);
    write_reg(REG_COLOR_END, 32'h0000_0000);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'h000, 12'h000);
    drain();

    // random phases with fresh settings
    for (int ph = 0; ph < 24; ph++) begin
      random_setup();
      if (ph >= 20) calm = 1;
      for (int n = 0; n < 39; n++) begin
        if ($urandom_range(0, 3) == 0)
          send_pixel(12'($urandom()), 12'($urandom()));
        else
          send_pixel(12'($urandom_range(0, 600)), 12'($urandom_range(0, 600)));
      end
      drain();
    end

    $display("run: %0d pixels over linear and radial phases, %0d colours checked",
             pix_total, argb_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/gpg_pkg.sv
rtl/core/gpg_if.sv
rtl/core/gpg_cfg.sv
rtl/core/gpg_front.sv
rtl/core/gpg_sqrt.sv
rtl/core/gpg_div.sv
rtl/core/gpg_blend.sv
rtl/core/gradient_pixel_generator_unit.sv
verif/gpg_checker.sv
verif/tb_gradient_pixel_generator_unit.sv
